FILE: sv/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define CHK_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/cfpsg_pkg.sv
// Types and constants of the coplanar-free point set grower.
package cfpsg_pkg;

   localparam int CFG_WIDTH   = 8;
   localparam int COUNT_OUT_W = 8;
   localparam logic [CFG_WIDTH-1:0] CAP_RESET = 8'd128;

   localparam logic ACT_OFFER    = 1'b0;
   localparam logic ACT_TRUNCATE = 1'b1;

   typedef enum logic [2:0] {
      V_ADDED     = 3'd0,
      V_DUPLICATE = 3'd1,
      V_COLLINEAR = 3'd2,
      V_COPLANAR  = 3'd3,
      V_FULL      = 3'd4
   } verdict_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DUP_RD,
      S_DUP_CHK,
      S_A_RD,
      S_A_LD,
      S_B_RD,
      S_B_LD,
      S_CROSS,
      S_CROSS_CHK,
      S_C_RD,
      S_C_LD,
      S_DET,
      S_DET_CHK,
      S_APPEND,
      S_DONE
   } state_type;

endpackage

FILE: sv/coplanar_free_point_set_grower.sv
// Top level: point set grower with a shared multiply-accumulate and a scan sequencer.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------------------
//   req     | in        | req_valid / req_stall    | action, point_x/y/z, keep_count
//   rsp     | out       | rsp_valid / rsp_stall    | accepted, verdict, set_count
//   csr     | in        | csr_write_enable         | csr_write_data (capacity limit)
//
// One transaction at a time: req_stall is high from acceptance until the result is
// loaded into the output register. An offer reads the stored points through the one
// read port and scans them with the one multiplier (six steps per pair, three per
// triple); a truncate skips the scan. Reset is synchronous: the set empties, the
// capacity returns to 128. A stalled result holds; the next request is still taken,
// and its result waits until the register frees.
module coplanar_free_point_set_grower #(
   parameter int MAX_POINTS = 128,
   parameter int COORD_BITS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [COORD_BITS-1:0] req_point_x,
   input  logic [COORD_BITS-1:0] req_point_y,
   input  logic [COORD_BITS-1:0] req_point_z,
   input  logic [7:0]            req_keep_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_accepted,
   output logic [2:0]            rsp_verdict,
   output logic [7:0]            rsp_set_count,
   input  logic                  csr_write_enable,
   input  logic [7:0]            csr_write_data
);

   localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int LW  = (CW > cfpsg_pkg::CFG_WIDTH) ? CW : cfpsg_pkg::CFG_WIDTH;
   localparam int PTW = 3 * COORD_BITS;
   localparam int DW  = COORD_BITS + 1;     // signed coordinate difference
   localparam int XW  = 2 * DW + 1;         // cross product component
   localparam int PW  = DW + XW;            // multiplier product
   localparam int AW  = PW + 2;             // accumulator

   // Sequencer and counters
   cfpsg_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [2:0]    op_ff, op_in;
   logic [cfpsg_pkg::CFG_WIDTH-1:0] cap_ff, cap_in;

   // Operand registers
   logic [PTW-1:0] q_ff, q_in, a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [XW-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [AW-1:0] acc_ff, acc_in;

   // Pending result and output register
   logic                   res_accepted_ff, res_accepted_in;
   cfpsg_pkg::verdict_type res_verdict_ff, res_verdict_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_accepted_ff, rsp_accepted_in;
   cfpsg_pkg::verdict_type rsp_verdict_ff, rsp_verdict_in;
   logic [7:0]             rsp_count_ff, rsp_count_in;

   // Point memory, one write and one registered read port
   logic [PTW-1:0] mem [MAX_POINTS];
   logic [PTW-1:0] rd_data_ff;
   logic [IW-1:0]  rd_addr;

   logic req_take, out_free, set_full, few_points, dup_hit, cross_zero, det_zero;
   logic signed [DW-1:0] ux, uy, uz, vx, vy, vz, wx, wy, wz;
   logic signed [DW-1:0] mul_a;
   logic signed [XW-1:0] mul_b;
   logic signed [PW-1:0] prod;
   logic signed [AW-1:0] acc_base, acc_next;
   logic                 mac_sub, mac_clear;

   function automatic logic signed [DW-1:0] axis_diff(
      input logic [PTW-1:0] p,
      input logic [PTW-1:0] r,
      input int             axis
   );
      logic [DW-1:0] pe, re;
      pe = DW'(p[axis*COORD_BITS +: COORD_BITS]);
      re = DW'(r[axis*COORD_BITS +: COORD_BITS]);
      return $signed(pe - re);
   endfunction

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Full when the count reaches the register value or the storage depth
   assign set_full   = (LW'(count_ff) >= LW'(cap_ff)) || (count_ff >= CW'(MAX_POINTS));
   assign few_points = count_ff < CW'(2);
   assign dup_hit    = rd_data_ff == q_ff;
   assign cross_zero = (cx_ff == '0) && (cy_ff == '0) && (cz_ff == '0);
   assign det_zero   = acc_ff == '0;

   // Differences from the first point of the pair: u to b, v to candidate, w to c
   assign ux = axis_diff(b_ff, a_ff, 0);
   assign uy = axis_diff(b_ff, a_ff, 1);
   assign uz = axis_diff(b_ff, a_ff, 2);
   assign vx = axis_diff(q_ff, a_ff, 0);
   assign vy = axis_diff(q_ff, a_ff, 1);
   assign vz = axis_diff(q_ff, a_ff, 2);
   assign wx = axis_diff(c_ff, a_ff, 0);
   assign wy = axis_diff(c_ff, a_ff, 1);
   assign wz = axis_diff(c_ff, a_ff, 2);

   // Shared multiply-accumulate: operand pick per step
   always_comb begin
      mul_a = ux;
      mul_b = XW'(ux);
      if (state_ff == cfpsg_pkg::S_CROSS) begin
         case (op_ff)
            3'd0:    begin mul_a = uy; mul_b = XW'(vz); end
            3'd1:    begin mul_a = uz; mul_b = XW'(vy); end
            3'd2:    begin mul_a = uz; mul_b = XW'(vx); end
            3'd3:    begin mul_a = ux; mul_b = XW'(vz); end
            3'd4:    begin mul_a = ux; mul_b = XW'(vy); end
            default: begin mul_a = uy; mul_b = XW'(vx); end
         endcase
      end else begin
         case (op_ff)
            3'd0:    begin mul_a = wx; mul_b = cx_ff; end
            3'd1:    begin mul_a = wy; mul_b = cy_ff; end
            default: begin mul_a = wz; mul_b = cz_ff; end
         endcase
      end
   end

   // Cross steps pair up (plus, minus); a determinant starts clear at step zero
   assign mac_sub   = (state_ff == cfpsg_pkg::S_CROSS) && op_ff[0];
   assign mac_clear = (state_ff == cfpsg_pkg::S_CROSS) ? !op_ff[0] : (op_ff == 3'd0);
   assign prod      = mul_a * mul_b;
   assign acc_base  = mac_clear ? '0 : acc_ff;
   assign acc_next  = mac_sub ? (acc_base - AW'(prod)) : (acc_base + AW'(prod));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfpsg_pkg::S_IDLE: begin
            if (req_take) begin
               state_in = (req_action == cfpsg_pkg::ACT_TRUNCATE) ?
                          cfpsg_pkg::S_DONE : cfpsg_pkg::S_DUP_RD;
            end
         end
         cfpsg_pkg::S_DUP_RD: begin
            if (i_ff == count_ff) begin
               if (set_full)        state_in = cfpsg_pkg::S_DONE;
               else if (few_points) state_in = cfpsg_pkg::S_APPEND;
               else                 state_in = cfpsg_pkg::S_A_RD;
            end else begin
               state_in = cfpsg_pkg::S_DUP_CHK;
            end
         end
         cfpsg_pkg::S_DUP_CHK:
            state_in = dup_hit ? cfpsg_pkg::S_DONE : cfpsg_pkg::S_DUP_RD;
         cfpsg_pkg::S_A_RD:
            state_in = ((i_ff + CW'(1)) >= count_ff) ? cfpsg_pkg::S_APPEND : cfpsg_pkg::S_A_LD;
         cfpsg_pkg::S_A_LD:
            state_in = cfpsg_pkg::S_B_RD;
         cfpsg_pkg::S_B_RD:
            state_in = (j_ff == count_ff) ? cfpsg_pkg::S_A_RD : cfpsg_pkg::S_B_LD;
         cfpsg_pkg::S_B_LD:
            state_in = cfpsg_pkg::S_CROSS;
         cfpsg_pkg::S_CROSS:
            if (op_ff == 3'd5) state_in = cfpsg_pkg::S_CROSS_CHK;
         cfpsg_pkg::S_CROSS_CHK:
            state_in = cross_zero ? cfpsg_pkg::S_DONE : cfpsg_pkg::S_C_RD;
         cfpsg_pkg::S_C_RD:
            state_in = (k_ff == count_ff) ? cfpsg_pkg::S_B_RD : cfpsg_pkg::S_C_LD;
         cfpsg_pkg::S_C_LD:
            state_in = cfpsg_pkg::S_DET;
         cfpsg_pkg::S_DET:
            if (op_ff == 3'd2) state_in = cfpsg_pkg::S_DET_CHK;
         cfpsg_pkg::S_DET_CHK:
            state_in = det_zero ? cfpsg_pkg::S_DONE : cfpsg_pkg::S_C_RD;
         cfpsg_pkg::S_APPEND:
            state_in = cfpsg_pkg::S_DONE;
         cfpsg_pkg::S_DONE:
            if (out_free) state_in = cfpsg_pkg::S_IDLE;
         default:
            state_in = cfpsg_pkg::S_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake, read address, datapath updates
   always_comb begin
      req_stall       = state_ff != cfpsg_pkg::S_IDLE;
      rd_addr         = i_ff[IW-1:0];
      count_in        = count_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      k_in            = k_ff;
      op_in           = op_ff;
      q_in            = q_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      c_in            = c_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      cz_in           = cz_ff;
      acc_in          = acc_ff;
      res_accepted_in = res_accepted_ff;
      res_verdict_in  = res_verdict_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_verdict_in  = rsp_verdict_ff;
      rsp_count_in    = rsp_count_ff;
      cap_in          = csr_write_enable ? csr_write_data : cap_ff;

      unique case (state_ff)
         cfpsg_pkg::S_IDLE: begin
            if (req_take) begin
               q_in            = {req_point_z, req_point_y, req_point_x};
               i_in            = '0;
               res_accepted_in = 1'b0;
               res_verdict_in  = cfpsg_pkg::V_ADDED;
               // Truncate only shortens the set
               if ((req_action == cfpsg_pkg::ACT_TRUNCATE) &&
                   (LW'(req_keep_count) < LW'(count_ff))) begin
                  count_in = CW'(req_keep_count);
               end
            end
         end
         cfpsg_pkg::S_DUP_RD: begin
            if (i_ff == count_ff) begin
               if (set_full) res_verdict_in = cfpsg_pkg::V_FULL;
               i_in = '0;
            end
         end
         cfpsg_pkg::S_DUP_CHK: begin
            if (dup_hit) res_verdict_in = cfpsg_pkg::V_DUPLICATE;
            else         i_in = i_ff + CW'(1);
         end
         cfpsg_pkg::S_A_RD: ;
         cfpsg_pkg::S_A_LD: begin
            a_in = rd_data_ff;
            j_in = i_ff + CW'(1);
         end
         cfpsg_pkg::S_B_RD: begin
            rd_addr = j_ff[IW-1:0];
            if (j_ff == count_ff) i_in = i_ff + CW'(1);
         end
         cfpsg_pkg::S_B_LD: begin
            b_in  = rd_data_ff;
            op_in = '0;
         end
         cfpsg_pkg::S_CROSS: begin
            acc_in = acc_next;
            op_in  = op_ff + 3'd1;
            if (op_ff == 3'd1) cx_in = XW'(acc_next);
            if (op_ff == 3'd3) cy_in = XW'(acc_next);
            if (op_ff == 3'd5) cz_in = XW'(acc_next);
         end
         cfpsg_pkg::S_CROSS_CHK: begin
            if (cross_zero) res_verdict_in = cfpsg_pkg::V_COLLINEAR;
            else            k_in = j_ff + CW'(1);
         end
         cfpsg_pkg::S_C_RD: begin
            rd_addr = k_ff[IW-1:0];
            if (k_ff == count_ff) j_in = j_ff + CW'(1);
         end
         cfpsg_pkg::S_C_LD: begin
            c_in  = rd_data_ff;
            op_in = '0;
         end
         cfpsg_pkg::S_DET: begin
            acc_in = acc_next;
            op_in  = op_ff + 3'd1;
         end
         cfpsg_pkg::S_DET_CHK: begin
            if (det_zero) res_verdict_in = cfpsg_pkg::V_COPLANAR;
            else          k_in = k_ff + CW'(1);
         end
         cfpsg_pkg::S_APPEND: begin
            count_in        = count_ff + CW'(1);
            res_accepted_in = 1'b1;
            res_verdict_in  = cfpsg_pkg::V_ADDED;
         end
         cfpsg_pkg::S_DONE: begin
            // Load the output register once it is free
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = res_accepted_ff;
               rsp_verdict_in  = res_verdict_ff;
               rsp_count_in    = 8'(count_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfpsg_pkg::S_IDLE;
         count_ff     <= '0;
         cap_ff       <= cfpsg_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff            <= i_in;
      j_ff            <= j_in;
      k_ff            <= k_in;
      op_ff           <= op_in;
      q_ff            <= q_in;
      a_ff            <= a_in;
      b_ff            <= b_in;
      c_ff            <= c_in;
      cx_ff           <= cx_in;
      cy_ff           <= cy_in;
      cz_ff           <= cz_in;
      acc_ff          <= acc_in;
      res_accepted_ff <= res_accepted_in;
      res_verdict_ff  <= res_verdict_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_verdict_ff  <= rsp_verdict_in;
      rsp_count_ff    <= rsp_count_in;
   end

   // Append writes at the current count; reads are registered
   always_ff @(posedge clock) begin
      if (state_ff == cfpsg_pkg::S_APPEND) mem[count_ff[IW-1:0]] <= q_ff;
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_verdict   = rsp_verdict_ff;
   assign rsp_set_count = rsp_count_ff;

endmodule

FILE: sv/cfpsg_checker.sv
// Port-level checker of the point set grower and its bind.
`include "assert_macros.svh"

module cfpsg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_action,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_accepted,
   input logic [2:0] rsp_verdict,
   input logic [7:0] rsp_set_count
);

   logic        req_take;
   logic [11:0] rsp_fields;

   assign req_take   = req_valid && !req_stall;
   assign rsp_fields = {rsp_accepted, rsp_verdict, rsp_set_count};

   // A stalled result holds
   `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fields), "stalled result changed")

   // An appended point always reports the added verdict and a nonempty set
   `CHK_IMPLIES(a_accept_verdict, rsp_valid && rsp_accepted, (rsp_verdict == cfpsg_pkg::V_ADDED) && (rsp_set_count != 8'd0), "bad accepted result")

   // The request side is busy in the cycle after a transaction is taken
   `CHK_NEXT(a_busy_after_take, req_take, req_stall, "request side not busy after a transaction")

   // A truncate never shows up as a fresh appended result in the next cycle
   `CHK_NEXT(a_trunc_no_append, req_take && (req_action == cfpsg_pkg::ACT_TRUNCATE), !(rsp_valid && rsp_accepted && !rsp_stall) || $past(rsp_valid), "truncate produced an append")

endmodule

bind coplanar_free_point_set_grower cfpsg_checker u_cfpsg_checker (.*);

FILE: test/coplanar_free_point_set_grower_tb.sv
// Self-checking testbench for the coplanar-free point set grower: directed and random transactions.
module coplanar_free_point_set_grower_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_POINTS  = 128;
   localparam int COORD_BITS  = 4;
   localparam int HOLD_CYCLES = 150;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
   } grid_point_type;

   typedef struct {
      logic                   accepted;
      cfpsg_pkg::verdict_type verdict;
      logic [7:0]             set_count;
   } outcome_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_action = cfpsg_pkg::ACT_OFFER;
   logic [COORD_BITS-1:0] req_point_x = '0;
   logic [COORD_BITS-1:0] req_point_y = '0;
   logic [COORD_BITS-1:0] req_point_z = '0;
   logic [7:0]            req_keep_count = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_accepted;
   logic [2:0]            rsp_verdict;
   logic [7:0]            rsp_set_count;
   logic                  csr_write_enable = 1'b0;
   logic [7:0]            csr_write_data = '0;

   // Shadow copy of the block state, kept in step with accepted transactions.
   grid_point_type set_model [MAX_POINTS];
   int             set_size = 0;
   logic [7:0]     capacity_model = cfpsg_pkg::CAP_RESET;

   outcome_type pending_outcomes [$];

   int  failures = 0;
   int  items_sent = 0;
   int  truncates_sent = 0;
   int  capacity_writes = 0;
   int  verdict_tally [5] = '{default: 0};
   bit  quiet = 1'b1;       // no gaps on either side while set
   bit  hold_request = 1'b0; // ask the result side for one long hold-off

   coplanar_free_point_set_grower #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .req_keep_count  (req_keep_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_verdict     (rsp_verdict),
      .rsp_set_count   (rsp_set_count),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Geometry scan over stored pairs in index order: a pair collinear with the
   // candidate stops the scan, then every triple that extends the pair is tested
   // for a zero determinant. The first failing test wins.
   function automatic cfpsg_pkg::verdict_type scan_geometry(grid_point_type q);
      int ux, uy, uz, vx, vy, vz, wx, wy, wz, cx, cy, cz, det;
      for (int i = 0; i < set_size; i++) begin
         for (int j = i + 1; j < set_size; j++) begin
            ux = int'(set_model[j].x) - int'(set_model[i].x);
            uy = int'(set_model[j].y) - int'(set_model[i].y);
            uz = int'(set_model[j].z) - int'(set_model[i].z);
            vx = int'(q.x) - int'(set_model[i].x);
            vy = int'(q.y) - int'(set_model[i].y);
            vz = int'(q.z) - int'(set_model[i].z);
            cx = uy * vz - uz * vy;
            cy = uz * vx - ux * vz;
            cz = ux * vy - uy * vx;
            if (cx == 0 && cy == 0 && cz == 0)
               return cfpsg_pkg::V_COLLINEAR;
            for (int k = j + 1; k < set_size; k++) begin
               wx = int'(set_model[k].x) - int'(set_model[i].x);
               wy = int'(set_model[k].y) - int'(set_model[i].y);
               wz = int'(set_model[k].z) - int'(set_model[i].z);
               det = wx * cx + wy * cy + wz * cz;
               if (det == 0)
                  return cfpsg_pkg::V_COPLANAR;
            end
         end
      end
      return cfpsg_pkg::V_ADDED;
   endfunction

   // Apply one transaction to the shadow set and return the result it must produce.
   function automatic outcome_type grow_point_set(logic action, grid_point_type q,
                                                  logic [7:0] keep);
      outcome_type result;
      bit          dup;
      int          limit;
      result.accepted = 1'b0;
      result.verdict  = cfpsg_pkg::V_ADDED;
      if (action == cfpsg_pkg::ACT_TRUNCATE) begin
         if (int'(keep) < set_size)
            set_size = int'(keep);
      end else begin
         dup = 1'b0;
         for (int i = 0; i < set_size; i++)
            if (set_model[i] == q)
               dup = 1'b1;
         limit = (int'(capacity_model) < MAX_POINTS) ? int'(capacity_model) : MAX_POINTS;
         if (dup) begin
            result.verdict = cfpsg_pkg::V_DUPLICATE;
         end else if (set_size >= limit) begin
            result.verdict = cfpsg_pkg::V_FULL;
         end else begin
            result.verdict = scan_geometry(q);
            if (result.verdict == cfpsg_pkg::V_ADDED) begin
               set_model[set_size] = q;
               set_size++;
               result.accepted = 1'b1;
            end
         end
      end
      result.set_count = set_size[7:0];
      return result;
   endfunction

   // Mostly back to back, sometimes a short gap, rarely a long gap.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Drive one request transaction, hold it until the block takes it, then drop
   // valid at the next falling edge so the taken payload is never offered again.
   task automatic send_item(logic action, grid_point_type q, logic [7:0] keep);
      int gap;
      gap = quiet ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_point_x    <= q.x;
      req_point_y    <= q.y;
      req_point_z    <= q.z;
      req_keep_count <= keep;
      do @(posedge clock); while (req_stall);
      pending_outcomes.push_back(grow_point_set(action, q, keep));
      items_sent++;
      if (action == cfpsg_pkg::ACT_TRUNCATE)
         truncates_sent++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic offer(int x, int y, int z);
      grid_point_type q;
      q.x = x[COORD_BITS-1:0];
      q.y = y[COORD_BITS-1:0];
      q.z = z[COORD_BITS-1:0];
      send_item(cfpsg_pkg::ACT_OFFER, q, 8'($urandom));
   endtask

   task automatic truncate(int keep);
      // coordinates are don't-care on truncate: randomize them
      send_item(cfpsg_pkg::ACT_TRUNCATE, grid_point_type'($urandom), 8'(keep));
   endtask

   // Drop valid and wait until every expected result has been taken.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Write the capacity register only while the block is idle.
   task automatic set_capacity(logic [7:0] cap);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      capacity_model = cap;
      capacity_writes++;
   endtask

   // Reflect a through b along one axis, so that a, b and the result line up;
   // fall back to the midpoint when the reflection leaves the grid.
   function automatic logic [COORD_BITS-1:0] extend_axis(int a, int b);
      int t;
      t = 2 * b - a;
      if (t < 0 || t > (1 << COORD_BITS) - 1)
         t = (a + b) / 2;
      return t[COORD_BITS-1:0];
   endfunction

   // One random transaction: duplicates and aligned points mixed into uniform
   // points, with truncates that keep the set small so each scan stays short.
   task automatic random_item();
      grid_point_type q, a, b;
      int             r;
      r = $urandom_range(99);
      if (set_size >= 12 || r < 12) begin
         truncate((r < 2) ? 128 : $urandom_range(set_size + 2, 0));
      end else begin
         r = $urandom_range(99);
         q = grid_point_type'($urandom);
         if (set_size > 0 && r < 15) begin
            q = set_model[$urandom_range(set_size - 1)];
         end else if (set_size >= 2 && r < 30) begin
            a = set_model[$urandom_range(set_size - 1)];
            b = set_model[$urandom_range(set_size - 1)];
            q.x = extend_axis(a.x, b.x);
            q.y = extend_axis(a.y, b.y);
            q.z = extend_axis(a.z, b.z);
         end
         send_item(cfpsg_pkg::ACT_OFFER, q, 8'($urandom));
      end
   endtask

   // Grid corners, duplicates, a collinear and a coplanar candidate on a tiny set.
   task automatic test_small_set_rules();
      offer(0, 0, 0);
      offer(0, 0, 0);
      offer(15, 15, 15);
      offer(2, 2, 2);
      offer(1, 0, 0);
      offer(0, 1, 1);
      offer(15, 0, 15);
   endtask

   // Truncate above the count, then down to a few points, then to empty.
   task automatic test_truncate();
      truncate(128);
      truncate(2);
      truncate(0);
      offer(8, 4, 2);
      truncate(1);
   endtask

   // Capacity zero, capacity one, a value above the set size, and a capacity
   // lowered below the current count.
   task automatic test_capacity_rules();
      truncate(0);
      set_capacity(8'd0);
      offer(3, 5, 7);
      set_capacity(8'd1);
      offer(3, 5, 7);
      offer(3, 5, 7);
      offer(9, 9, 9);
      set_capacity(8'd255);
      offer(9, 9, 9);
      offer(5, 12, 1);
      offer(14, 2, 8);
      set_capacity(8'd2);
      offer(7, 0, 13);
      offer(3, 5, 7);
      truncate(1);
      offer(7, 0, 13);
      set_capacity(cfpsg_pkg::CAP_RESET);
   endtask

   // Hold the result side off for a long stretch while requests keep coming, so
   // the output register fills and the block stalls its input.
   task automatic test_backpressure();
      truncate(0);
      drain();
      hold_request = 1'b1;
      repeat (6) random_item();
      drain();
   endtask

   // Random phases over several capacity settings, one of them with no gaps.
   task automatic test_random_growth();
      logic [7:0] caps [4];
      caps = '{cfpsg_pkg::CAP_RESET, 8'($urandom_range(12, 3)), 8'd255,
               8'($urandom_range(6, 1))};
      for (int p = 0; p < 4; p++) begin
         set_capacity(caps[p]);
         quiet = (p == 2);
         repeat (25) random_item();
      end
      drain();
   endtask

   // Result side: random stall stretches, one long hold-off on request.
   always begin : stall_results
      int n;
      @(negedge clock);
      if (hold_request) begin
         rsp_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         rsp_stall <= 1'b0;
         hold_request = 1'b0;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         n = pick_gap();
         if (n == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare every result transaction with the oldest expectation.
   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("result with nothing expected: accepted %0d verdict %0d count %0d",
                   rsp_accepted, rsp_verdict, rsp_set_count);
            failures++;
         end else begin
            want = pending_outcomes.pop_front();
            verdict_tally[want.verdict]++;
            if (rsp_accepted !== want.accepted) begin
               $error("accepted: expected %0d, actual %0d", want.accepted, rsp_accepted);
               failures++;
            end
            if (rsp_verdict !== want.verdict) begin
               $error("verdict: expected %0d, actual %0d", want.verdict, rsp_verdict);
               failures++;
            end
            if (rsp_set_count !== want.set_count) begin
               $error("set_count: expected %0d, actual %0d", want.set_count, rsp_set_count);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_small_set_rules();
      test_truncate();
      test_capacity_rules();
      test_backpressure();
      test_random_growth();

      // look for stray results after the last expected one
      repeat (100) @(posedge clock);

      $display("Sent %0d transactions (%0d truncates) over %0d capacity writes.",
               items_sent, truncates_sent, capacity_writes);
      $display("Verdicts: %0d appended/truncated, %0d duplicate, %0d collinear, %0d coplanar, %0d full.",
               verdict_tally[cfpsg_pkg::V_ADDED], verdict_tally[cfpsg_pkg::V_DUPLICATE],
               verdict_tally[cfpsg_pkg::V_COLLINEAR], verdict_tally[cfpsg_pkg::V_COPLANAR],
               verdict_tally[cfpsg_pkg::V_FULL]);
      if (failures == 0 && pending_outcomes.size() == 0) begin
         $display("[coplanar_free_point_set_grower] OK");
      end else begin
         $display("[coplanar_free_point_set_grower] ERROR");
      end
      $finish;
   end

   // Watchdog: the slowest legal run is well under a tenth of this.
   initial begin
      #30_000_000;
      $display("[coplanar_free_point_set_grower] ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/cfpsg_pkg.sv
sv/coplanar_free_point_set_grower.sv
sv/cfpsg_checker.sv
test/coplanar_free_point_set_grower_tb.sv
